### hw/rtl/mlc_pkg.sv
// Shared types, register indexes and region-code helpers for the line clipper.
package mlc_pkg;

   localparam int CoordBits = 16;
   localparam int StopBits  = 16;
   localparam int MaxSteps  = 48;

   localparam logic [3:0] CodeTop    = 4'h8;
   localparam logic [3:0] CodeBottom = 4'h4;
   localparam logic [3:0] CodeRight  = 4'h2;
   localparam logic [3:0] CodeLeft   = 4'h1;

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef enum logic [2:0] {
      REG_WINDOW_LEFT   = 3'd0,
      REG_WINDOW_RIGHT  = 3'd1,
      REG_WINDOW_TOP    = 3'd2,
      REG_WINDOW_BOTTOM = 3'd3,
      REG_STOP_DIST_SQ  = 3'd4
   } csr_index_type;

   typedef struct packed {
      coord_type left;
      coord_type right;
      coord_type top;
      coord_type bottom;
   } window_type;

   // Progress of one segment as it moves down the cell row.
   typedef struct packed {
      logic        valid;
      logic        visible;
      logic [1:0]  taken;
      coord_type   near_x;
      coord_type   near_y;
      coord_type   far_x;
      coord_type   far_y;
      coord_type   home_x;
      coord_type   home_y;
      coord_type   first_x;
      coord_type   first_y;
      coord_type   second_x;
      coord_type   second_y;
   } cell_state_type;

   function automatic logic [3:0] outcode(window_type win, coord_type px, coord_type py);
      logic [3:0] c;
      c = 4'h0;
      if (py < win.top)    c = c | CodeTop;
      if (py > win.bottom) c = c | CodeBottom;
      if (px > win.right)  c = c | CodeRight;
      if (px < win.left)   c = c | CodeLeft;
      return c;
   endfunction

endpackage

### hw/rtl/midpoint_line_clipper_unit.sv
// Top level of the midpoint subdivision line clipper: setup, cell row and result register.
// Each segment passes a setup register, a row of 48 subdivision cells (one search
// iteration per cell) and a result register, in that order; the row is a pipeline that
// takes one segment per cycle unless a stall on the result side holds it.
// A stall on the result side freezes the whole row. Window and threshold registers
// are read by every cell and should be written only while no segment is in flight.
module midpoint_line_clipper_unit
   import mlc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_start_x,
   input  logic signed [15:0]   req_start_y,
   input  logic signed [15:0]   req_end_x,
   input  logic signed [15:0]   req_end_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_visible,
   output logic signed [15:0]   rsp_first_x,
   output logic signed [15:0]   rsp_first_y,
   output logic signed [15:0]   rsp_second_x,
   output logic signed [15:0]   rsp_second_y,
   output logic                 rsp_step_cap_hit,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_write_data
);

   window_type          window_ff;
   logic [StopBits-1:0] stop_dist_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.left   <= 16'sd0;
         window_ff.right  <= 16'sd16383;
         window_ff.top    <= 16'sd0;
         window_ff.bottom <= 16'sd16383;
         stop_dist_sq_ff  <= 16'd3;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_WINDOW_LEFT:   window_ff.left   <= csr_write_data;
            REG_WINDOW_RIGHT:  window_ff.right  <= csr_write_data;
            REG_WINDOW_TOP:    window_ff.top    <= csr_write_data;
            REG_WINDOW_BOTTOM: window_ff.bottom <= csr_write_data;
            REG_STOP_DIST_SQ:  stop_dist_sq_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Setup: trivial reject and trivial accept are resolved before the row.
   logic [3:0]     code_start;
   logic [3:0]     code_end;
   cell_state_type setup_in;
   cell_state_type setup_ff;

   always_comb begin
      code_start = outcode(window_ff, req_start_x, req_start_y);
      code_end   = outcode(window_ff, req_end_x, req_end_y);
      setup_in          = '0;
      setup_in.valid    = req_valid;
      setup_in.near_x   = req_start_x;
      setup_in.near_y   = req_start_y;
      setup_in.far_x    = req_end_x;
      setup_in.far_y    = req_end_y;
      setup_in.home_x   = req_start_x;
      setup_in.home_y   = req_start_y;
      if ((code_start & code_end) != 4'h0) begin
         setup_in.taken   = 2'd2;
         setup_in.visible = 1'b0;
      end else if (code_start == 4'h0 && code_end == 4'h0) begin
         setup_in.taken    = 2'd2;
         setup_in.visible  = 1'b1;
         setup_in.first_x  = req_start_x;
         setup_in.first_y  = req_start_y;
         setup_in.second_x = req_end_x;
         setup_in.second_y = req_end_y;
      end else begin
         setup_in.taken   = 2'd0;
         setup_in.visible = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= '0;
      end else if (advance) begin
         setup_ff <= setup_in;
      end
   end

   cell_state_type chain [0:MaxSteps];
   assign chain[0] = setup_ff;

   for (genvar i = 0; i < MaxSteps; i++) begin : g_cell
      mlc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .window       (window_ff),
         .stop_dist_sq (stop_dist_sq_ff),
         .state_in     (chain[i]),
         .state_out    (chain[i+1])
      );
   end

   // Result register; unfinished searches take the pending far end and raise the cap flag.
   cell_state_type last;
   logic           cap_in;
   coord_type      first_x_in;
   coord_type      first_y_in;
   coord_type      second_x_in;
   coord_type      second_y_in;
   logic           visible_ff;
   logic           cap_ff;
   coord_type      first_x_ff;
   coord_type      first_y_ff;
   coord_type      second_x_ff;
   coord_type      second_y_ff;

   always_comb begin
      last        = chain[MaxSteps];
      cap_in      = last.taken != 2'd2;
      first_x_in  = (last.taken == 2'd0) ? last.far_x : last.first_x;
      first_y_in  = (last.taken == 2'd0) ? last.far_y : last.first_y;
      second_x_in = (last.taken != 2'd2) ? last.far_x : last.second_x;
      second_y_in = (last.taken != 2'd2) ? last.far_y : last.second_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         visible_ff  <= last.visible;
         cap_ff      <= cap_in;
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         second_x_ff <= second_x_in;
         second_y_ff <= second_y_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visible      = visible_ff;
   assign rsp_step_cap_hit = cap_ff;
   assign rsp_first_x      = first_x_ff;
   assign rsp_first_y      = first_y_ff;
   assign rsp_second_x     = second_x_ff;
   assign rsp_second_y     = second_y_ff;

   a_reject_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_first_x == 16'sd0 && rsp_first_y == 16'sd0
         && rsp_second_x == 16'sd0 && rsp_second_y == 16'sd0 && !rsp_step_cap_hit)
      else $error("rejected segment carries nonzero points");

   a_row_exit_shows: assert property (@(posedge clock) disable iff (reset)
      chain[MaxSteps].valid && advance |=> rsp_valid)
      else $error("segment leaving the cell row was lost");

   a_frozen_row: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[MaxSteps]))
      else $error("cell row moved while the result was stalled");

endmodule

### hw/rtl/mlc_cell.sv
// One subdivision cell: performs a single search iteration and registers the result.
module mlc_cell
   import mlc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  window_type     window,
   input  logic [StopBits-1:0] stop_dist_sq,
   input  cell_state_type state_in,
   output cell_state_type state_out
);

   cell_state_type state_ff;
   cell_state_type state_in_next;

   logic signed [CoordBits:0] dx;
   logic signed [CoordBits:0] dy;
   logic [CoordBits:0]        abs_dx;
   logic [CoordBits:0]        abs_dy;
   logic [2*CoordBits-1:0]    sq_x;
   logic [2*CoordBits-1:0]    sq_y;
   logic [2*CoordBits:0]      dist_sq;
   logic                      far_enough;
   logic [3:0]                code_far;
   logic [3:0]                code_mid;
   logic signed [CoordBits:0] sum_x;
   logic signed [CoordBits:0] sum_y;
   coord_type                 mid_x;
   coord_type                 mid_y;

   always_comb begin
      dx = {state_in.near_x[CoordBits-1], state_in.near_x}
         - {state_in.far_x[CoordBits-1], state_in.far_x};
      dy = {state_in.near_y[CoordBits-1], state_in.near_y}
         - {state_in.far_y[CoordBits-1], state_in.far_y};
      abs_dx = dx[CoordBits] ? -dx : dx;
      abs_dy = dy[CoordBits] ? -dy : dy;
      sq_x = abs_dx[CoordBits-1:0] * abs_dx[CoordBits-1:0];
      sq_y = abs_dy[CoordBits-1:0] * abs_dy[CoordBits-1:0];
      dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
      far_enough = dist_sq > {{(2*CoordBits+1-StopBits){1'b0}}, stop_dist_sq};

      sum_x = {state_in.near_x[CoordBits-1], state_in.near_x}
            + {state_in.far_x[CoordBits-1], state_in.far_x};
      sum_y = {state_in.near_y[CoordBits-1], state_in.near_y}
            + {state_in.far_y[CoordBits-1], state_in.far_y};
      // Arithmetic shift of the sum gives the floored midpoint.
      mid_x = sum_x[CoordBits:1];
      mid_y = sum_y[CoordBits:1];

      code_far = outcode(window, state_in.far_x, state_in.far_y);
      code_mid = outcode(window, mid_x, mid_y);

      state_in_next = state_in;
      if (state_in.valid && state_in.taken != 2'd2) begin
         if (code_far != 4'h0 && far_enough) begin
            if ((code_mid & code_far) != 4'h0) begin
               state_in_next.far_x = mid_x;
               state_in_next.far_y = mid_y;
            end else begin
               state_in_next.near_x = mid_x;
               state_in_next.near_y = mid_y;
            end
         end else begin
            if (state_in.taken == 2'd0) begin
               state_in_next.first_x = state_in.far_x;
               state_in_next.first_y = state_in.far_y;
            end else begin
               state_in_next.second_x = state_in.far_x;
               state_in_next.second_y = state_in.far_y;
            end
            state_in_next.taken  = state_in.taken + 2'd1;
            state_in_next.near_x = state_in.far_x;
            state_in_next.near_y = state_in.far_y;
            state_in_next.far_x  = state_in.home_x;
            state_in_next.far_y  = state_in.home_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in_next;
      end
   end

   assign state_out = state_ff;

endmodule
